FILE: design/orsfe_pkg.sv
package orsfe_pkg;

  localparam int ID_FIELD_W = 7;
  localparam int DUR_W      = 16;
  localparam int REG_IDX_W  = 3;

  // Register indexes on the write port
  localparam logic [REG_IDX_W-1:0] REG_SHORT_HIGH = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SHORT_LOW  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LONG_HIGH  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LONG_LOW   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_GAP  = 3'd4;

  // Reset durations, microseconds
  localparam logic [DUR_W-1:0] RST_SHORT_HIGH = 16'd280;
  localparam logic [DUR_W-1:0] RST_SHORT_LOW  = 16'd360;
  localparam logic [DUR_W-1:0] RST_LONG_HIGH  = 16'd925;
  localparam logic [DUR_W-1:0] RST_LONG_LOW   = 16'd1000;
  localparam logic [DUR_W-1:0] RST_FRAME_GAP  = 16'd10000;

  // Pulses outside the id/preamble symbols: sync pair plus terminator
  localparam int SYNC_PULSES = 2;
  localparam int TERM_PULSES = 6;
  localparam int PREAMBLE_SYMS = 4;

  typedef struct packed {
    logic                  switch_on;
    logic [ID_FIELD_W-1:0] switch_id;
  } cmd_t;

  typedef struct packed {
    logic             level;
    logic [DUR_W-1:0] duration_us;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [DUR_W-1:0] short_high_us;
    logic [DUR_W-1:0] short_low_us;
    logic [DUR_W-1:0] long_high_us;
    logic [DUR_W-1:0] long_low_us;
    logic [DUR_W-1:0] frame_gap_us;
  } cfg_t;

endpackage

FILE: design/orsfe_cfg_regs.sv
module orsfe_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [orsfe_pkg::REG_IDX_W-1:0]   wr_index,
  input  logic [orsfe_pkg::DUR_W-1:0]       wr_data,
  output orsfe_pkg::cfg_t                   cfg
);

  orsfe_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.short_high_us <= orsfe_pkg::RST_SHORT_HIGH;
      regs.short_low_us  <= orsfe_pkg::RST_SHORT_LOW;
      regs.long_high_us  <= orsfe_pkg::RST_LONG_HIGH;
      regs.long_low_us   <= orsfe_pkg::RST_LONG_LOW;
      regs.frame_gap_us  <= orsfe_pkg::RST_FRAME_GAP;
    end else if (wr_en) begin
      case (wr_index)
        orsfe_pkg::REG_SHORT_HIGH: regs.short_high_us <= wr_data;
        orsfe_pkg::REG_SHORT_LOW:  regs.short_low_us  <= wr_data;
        orsfe_pkg::REG_LONG_HIGH:  regs.long_high_us  <= wr_data;
        orsfe_pkg::REG_LONG_LOW:   regs.long_low_us   <= wr_data;
        orsfe_pkg::REG_FRAME_GAP:  regs.frame_gap_us  <= wr_data;
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  assign cfg = regs;

endmodule

FILE: design/orsfe_pulse_gen.sv
module orsfe_pulse_gen #(
  parameter int ID_BITS = 7,
  parameter int CNT_W   = 6
) (
  input  logic [CNT_W-1:0]   idx,
  input  orsfe_pkg::cmd_t    cmd,
  input  orsfe_pkg::cfg_t    cfg,
  output orsfe_pkg::result_t pulse
);

  localparam int NUM_SYMS  = orsfe_pkg::PREAMBLE_SYMS + ID_BITS;
  localparam int SYM_W     = $clog2(NUM_SYMS);
  localparam int SYM_DEPTH = 2 ** SYM_W;
  localparam int TERM_BASE = orsfe_pkg::SYNC_PULSES + 4 * NUM_SYMS;

  logic [ID_BITS+orsfe_pkg::ID_FIELD_W-1:0] id_wide;
  logic [ID_BITS-1:0]   id_ext;
  logic [SYM_DEPTH-1:0] sym_bits;
  logic [CNT_W-1:0]     sym_off;
  logic [CNT_W-1:0]     term_off;
  logic [SYM_W-1:0]     sym;
  logic [1:0]           phase;
  logic                 bit_one;

  // id bits beyond the input field go out as zero
  assign id_wide = {{ID_BITS{1'b0}}, cmd.switch_id};
  assign id_ext  = id_wide[ID_BITS-1:0];
  // symbol 0 is the preamble one, symbols 1..3 preamble zeros, then the id LSB first
  assign sym_bits = SYM_DEPTH'({id_ext, 3'b000, 1'b1});

  assign sym_off  = idx - CNT_W'(orsfe_pkg::SYNC_PULSES);
  assign term_off = idx - CNT_W'(TERM_BASE);
  assign sym      = sym_off[SYM_W+1:2];
  assign phase    = sym_off[1:0];
  assign bit_one  = sym_bits[sym];

  always_comb begin
    pulse.level       = 1'b0;
    pulse.duration_us = cfg.frame_gap_us;
    pulse.last        = 1'b0;
    if (idx < CNT_W'(orsfe_pkg::SYNC_PULSES)) begin
      pulse.level       = ~idx[0];
      pulse.duration_us = idx[0] ? cfg.frame_gap_us : cfg.short_high_us;
    end else if (idx < CNT_W'(TERM_BASE)) begin
      case (phase)
        2'd0: begin
          pulse.level       = 1'b1;
          pulse.duration_us = cfg.short_high_us;
        end
        2'd1: begin
          pulse.level       = 1'b0;
          pulse.duration_us = cfg.long_low_us;
        end
        2'd2: begin
          pulse.level       = 1'b1;
          pulse.duration_us = bit_one ? cfg.short_high_us : cfg.long_high_us;
        end
        default: begin
          pulse.level       = 1'b0;
          pulse.duration_us = bit_one ? cfg.long_low_us : cfg.short_low_us;
        end
      endcase
    end else begin
      case (term_off[2:0])
        3'd0, 3'd2: begin
          pulse.level       = 1'b1;
          pulse.duration_us = cmd.switch_on ? cfg.long_high_us : cfg.short_high_us;
        end
        3'd1, 3'd3: begin
          pulse.level       = 1'b0;
          pulse.duration_us = cmd.switch_on ? cfg.short_low_us : cfg.long_low_us;
        end
        3'd4: begin
          pulse.level       = 1'b1;
          pulse.duration_us = cfg.short_high_us;
        end
        default: begin
          pulse.level       = 1'b0;
          pulse.duration_us = cfg.frame_gap_us;
          pulse.last        = 1'b1;
        end
      endcase
    end
  end

endmodule

FILE: design/ook_remote_switch_frame_encoder.sv
// Channel   Ports                         Transfer when
// command   start, busy, cmd              start && !busy at a rising edge
// result    strobe, result                strobe high (one cycle, no back-pressure)
// config    wr_en, wr_index, wr_data      wr_en high at a rising edge
//
// One command yields 24 + 4*ID_BITS pulses (52 at ID_BITS = 7), one per cycle,
// paced by the pulse counter. The accept edge sets the counter and active flag;
// the first pulse then goes through the result register and transfers from it.
// busy drops in the cycle the final pulse is being registered, so the next
// command follows with no gap.
// rst (synchronous) clears the counter, strobe and restores default durations.
// The result side cannot stall; strobe is never held off.
module ook_remote_switch_frame_encoder #(
  parameter int ID_BITS = 7
) (
  input  logic                            clk,
  input  logic                            rst,
  // command channel
  input  logic                            start,
  output logic                            busy,
  input  orsfe_pkg::cmd_t                 cmd,
  // pulse output
  output logic                            strobe,
  output orsfe_pkg::result_t              result,
  // config write port
  input  logic                            wr_en,
  input  logic [orsfe_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [orsfe_pkg::DUR_W-1:0]     wr_data
);

  localparam int NUM_PULSES = orsfe_pkg::SYNC_PULSES
                            + 4 * (orsfe_pkg::PREAMBLE_SYMS + ID_BITS)
                            + orsfe_pkg::TERM_PULSES;
  localparam int CNT_W = $clog2(NUM_PULSES);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(NUM_PULSES - 1);

  orsfe_pkg::cfg_t    cfg;
  orsfe_pkg::cmd_t    cmd_q;
  orsfe_pkg::result_t pulse;

  logic             active;
  logic [CNT_W-1:0] cnt;
  logic             accept;
  logic             at_last;

  // Duration registers
  orsfe_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  // Maps the pulse index to level/duration/last
  orsfe_pulse_gen #(
    .ID_BITS (ID_BITS),
    .CNT_W   (CNT_W)
  ) u_pulse (
    .idx   (cnt),
    .cmd   (cmd_q),
    .cfg   (cfg),
    .pulse (pulse)
  );

  assign at_last = (cnt == LAST_IDX);
  // Free once the counter is on the final pulse; that pulse still lands in
  // the result register while the new command is captured.
  assign busy    = active & ~at_last;
  assign accept  = start & ~busy;

  // Command register and pulse counter
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (accept) begin
      active <= 1'b1;
      cnt    <= '0;
    end else if (active) begin
      if (at_last) begin
        active <= 1'b0;
        cnt    <= '0;
      end else begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
    end
  end

  // Result register: one pulse per active cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      result <= pulse;
    end
  end

endmodule

FILE: design/orsfe_checker.sv
module orsfe_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               strobe,
  input orsfe_pkg::result_t result
);

  // A frame opens with the sync high pulse via the counter and result registers
  a_frame_opens: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> ##1 (strobe && result.level && !result.last))
    else $error("frame did not open with a high pulse");

  // While busy, pulses keep coming
  a_busy_streams: assert property (@(posedge clk) disable iff (rst)
    busy |=> strobe)
    else $error("busy without a pulse following");

  // The closing pulse is the low frame gap
  a_last_is_low: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |-> !result.level)
    else $error("final pulse is not low");

  // Within a frame, levels alternate
  a_alternate: assert property (@(posedge clk) disable iff (rst)
    strobe && $past(strobe) && !$past(result.last) |->
      result.level != $past(result.level))
    else $error("pulse levels did not alternate");

endmodule

bind ook_remote_switch_frame_encoder orsfe_checker u_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import orsfe_pkg::*;

  // Id bits per frame; matches the default of the block under test.
  localparam int ID_BITS     = 7;
  localparam int NUM_REGS    = 5;
  localparam int RANDOM_CMDS = 310;
  // Generous: ~330 frames of 52 pulses plus idle gaps fit well inside this limit.
  localparam longint RUN_LIMIT_NS = 64'd5_000_000;

  // Expected-pulse tracker: keeps its own copy of the duration registers and
  // expands every accepted command into the full frame of pulses.
  class pulse_scoreboard;
    cfg_t    durations;
    result_t expected_pulses[$];
    int      errors;

    function new();
      errors = 0;
      reset_durations();
    endfunction

    function void reset_durations();
      durations.short_high_us = RST_SHORT_HIGH;
      durations.short_low_us  = RST_SHORT_LOW;
      durations.long_high_us  = RST_LONG_HIGH;
      durations.long_low_us   = RST_LONG_LOW;
      durations.frame_gap_us  = RST_FRAME_GAP;
    endfunction

    // Indexes past the register list are dropped by the block.
    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [DUR_W-1:0] data);
      case (idx)
        REG_SHORT_HIGH: durations.short_high_us = data;
        REG_SHORT_LOW:  durations.short_low_us  = data;
        REG_LONG_HIGH:  durations.long_high_us  = data;
        REG_LONG_LOW:   durations.long_low_us   = data;
        REG_FRAME_GAP:  durations.frame_gap_us  = data;
        default: ;
      endcase
    endfunction

    function void push_pulse(logic lvl, logic [DUR_W-1:0] dur);
      result_t p;
      p.level       = lvl;
      p.duration_us = dur;
      p.last        = 1'b0;
      expected_pulses.push_back(p);
    endfunction

    // One data symbol = four pulses; 1 and 0 differ only in the second pair.
    function void push_symbol(logic one);
      push_pulse(1'b1, durations.short_high_us);
      push_pulse(1'b0, durations.long_low_us);
      push_pulse(1'b1, one ? durations.short_high_us : durations.long_high_us);
      push_pulse(1'b0, one ? durations.long_low_us : durations.short_low_us);
    endfunction

    function void note_command(cmd_t c);
      result_t tail;
      // sync
      push_pulse(1'b1, durations.short_high_us);
      push_pulse(1'b0, durations.frame_gap_us);
      // preamble 1,0,0,0
      push_symbol(1'b1);
      push_symbol(1'b0);
      push_symbol(1'b0);
      push_symbol(1'b0);
      // id, LSB first
      for (int b = 0; b < ID_BITS; b++)
        push_symbol(c.switch_id[b]);
      // on/off terminator, then closing short high and frame gap
      for (int r = 0; r < 2; r++) begin
        push_pulse(1'b1, c.switch_on ? durations.long_high_us : durations.short_high_us);
        push_pulse(1'b0, c.switch_on ? durations.short_low_us : durations.long_low_us);
      end
      push_pulse(1'b1, durations.short_high_us);
      push_pulse(1'b0, durations.frame_gap_us);
      tail = expected_pulses.pop_back();
      tail.last = 1'b1;
      expected_pulses.push_back(tail);
    endfunction

    function void check(result_t got);
      result_t want;
      if (expected_pulses.size() == 0) begin
        $error("pulse with no command pending: level %0d duration_us %0d last %0d",
               got.level, got.duration_us, got.last);
        errors++;
        return;
      end
      want = expected_pulses.pop_front();
      if (got.level !== want.level) begin
        $error("level: expected %0d, actual %0d", want.level, got.level);
        errors++;
      end
      if (got.duration_us !== want.duration_us) begin
        $error("duration_us: expected %0d, actual %0d", want.duration_us, got.duration_us);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_pulses.size();
    endfunction
  endclass

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 start    = 1'b0;
  logic                 busy;
  cmd_t                 cmd      = '0;
  logic                 strobe;
  result_t              result;
  logic                 wr_en    = 1'b0;
  logic [REG_IDX_W-1:0] wr_index = '0;
  logic [DUR_W-1:0]     wr_data  = '0;

  pulse_scoreboard frames;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ook_remote_switch_frame_encoder u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .strobe   (strobe),
    .result   (result),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // Monitor: everything is sampled at the rising edge, before the block's
  // registers move, so register writes, command transfers and pulse
  // transfers are seen exactly as the block sees them.
  always @(posedge clk) begin
    if (!rst) begin
      if (wr_en)
        frames.write_reg(wr_index, wr_data);
      if (start && !busy)
        frames.note_command(cmd);
      if (strobe)
        frames.check(result);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

  function automatic cmd_t make_cmd(bit on, int id);
    cmd_t c;
    c.switch_on = on;
    c.switch_id = ID_FIELD_W'(id);
    return c;
  endfunction

  // Bias toward the extremes (zero, one, all ones); otherwise any 16-bit value.
  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 16'd1;
      2:       return '1;
      default: return DUR_W'($urandom);
    endcase
  endfunction

  function automatic cfg_t random_durations();
    cfg_t d;
    d.short_high_us = pick_duration();
    d.short_low_us  = pick_duration();
    d.long_high_us  = pick_duration();
    d.long_low_us   = pick_duration();
    d.frame_gap_us  = pick_duration();
    return d;
  endfunction

  // Called at a rising edge; leaves wr_en high for the caller to drop.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DUR_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
  endtask

  // partial: each register is written with probability one half, so some
  // phases keep earlier values. Now and then an unused index is hit too.
  task automatic load_durations(input cfg_t d, input bit partial);
    if (!partial || $urandom_range(0, 1)) write_reg(REG_SHORT_HIGH, d.short_high_us);
    if (!partial || $urandom_range(0, 1)) write_reg(REG_SHORT_LOW,  d.short_low_us);
    if (!partial || $urandom_range(0, 1)) write_reg(REG_LONG_HIGH,  d.long_high_us);
    if (!partial || $urandom_range(0, 1)) write_reg(REG_LONG_LOW,   d.long_low_us);
    if (!partial || $urandom_range(0, 1)) write_reg(REG_FRAME_GAP,  d.frame_gap_us);
    if ($urandom_range(0, 2) == 0)
      write_reg(REG_IDX_W'($urandom_range(NUM_REGS, 2**REG_IDX_W - 1)), DUR_W'($urandom));
    wr_en <= 1'b0;
  endtask

  // One command transfer: start stays up until an edge with busy low.
  task automatic send_command(input cmd_t c);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
  endtask

  // Sends commands in bursts. Gaps run up to longer than a frame so the
  // next start lands on any phase of the current frame, or after it.
  task automatic send_list(input cmd_t cmds[$]);
    int burst_left;
    int gap;
    bit start_low;
    start_low  = 1'b0;
    burst_left = $urandom_range(1, 8);
    foreach (cmds[i]) begin
      send_command(cmds[i]);
      start_low = 1'b0;
      burst_left--;
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
        if (gap > 0) begin
          start <= 1'b0;
          start_low = 1'b1;
          repeat (gap) @(posedge clk);
        end
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 25)
                                                 : $urandom_range(1, 6);
      end
    end
    if (!start_low)
      start <= 1'b0;
  endtask

  // Register writes only once every pulse of the last frame has been seen.
  task automatic wait_idle();
    do @(posedge clk); while (frames.pending() != 0 || busy);
  endtask

  initial begin
    int   corner_ids[6] = '{0, 127, 1, 64, 85, 42};
    cmd_t cmds[$];
    cfg_t d;
    int   sent;
    int   phase_len;
    int   drain;

    frames = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset durations: id extremes, single bits, alternating bits, on and off.
    cmds = {};
    foreach (corner_ids[i]) begin
      cmds.push_back(make_cmd(1'b1, corner_ids[i]));
      cmds.push_back(make_cmd(1'b0, corner_ids[i]));
    end
    send_list(cmds);

    // All durations zero; unused indexes written with all ones must not land.
    wait_idle();
    d = '0;
    for (int i = NUM_REGS; i < 2**REG_IDX_W; i++)
      write_reg(REG_IDX_W'(i), '1);
    load_durations(d, 1'b0);
    cmds = {};
    cmds.push_back(make_cmd(1'b1, 127));
    cmds.push_back(make_cmd(1'b0, 0));
    send_list(cmds);

    // All durations at maximum.
    wait_idle();
    d = '1;
    load_durations(d, 1'b0);
    cmds = {};
    cmds.push_back(make_cmd(1'b0, 127));
    cmds.push_back(make_cmd(1'b1, 0));
    send_list(cmds);

    // Distinct small values so any swapped register shows up.
    wait_idle();
    d.short_high_us = 16'd1;
    d.short_low_us  = 16'd2;
    d.long_high_us  = 16'd3;
    d.long_low_us   = 16'd4;
    d.frame_gap_us  = 16'd5;
    load_durations(d, 1'b0);
    cmds = {};
    cmds.push_back(make_cmd(1'b1, 85));
    cmds.push_back(make_cmd(1'b0, 42));
    send_list(cmds);

    // Random commands in phases, each phase under fresh random durations.
    sent = 0;
    while (sent < RANDOM_CMDS) begin
      phase_len = $urandom_range(15, 45);
      if (phase_len > RANDOM_CMDS - sent)
        phase_len = RANDOM_CMDS - sent;
      wait_idle();
      load_durations(random_durations(), $urandom_range(0, 2) == 0);
      cmds = {};
      repeat (phase_len)
        cmds.push_back(make_cmd(1'($urandom_range(0, 1)), $urandom_range(0, 127)));
      send_list(cmds);
      sent += phase_len;
    end

    // Drain: the last frame plus pipeline; allow plenty.
    drain = 0;
    while ((frames.pending() != 0 || busy) && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (frames.pending() != 0) begin
      $error("%0d expected pulses never arrived", frames.pending());
      frames.errors++;
    end

    if (frames.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
